[hdl/cbmt_pkg.sv]
// Package for the counter bank with maximum tracking.
// Holds field widths, action codes and the controller/datapath structs.
// No dependencies; every other file of the block uses it.
`default_nettype none

package cbmt_pkg;

  // Field widths of the transaction payloads.
  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 4;
  localparam int VALUE_W  = 16;
  localparam int NUM_W    = 5;

  // At most this many results are given for one listing.
  localparam int MAX_RESULTS = 16;
  localparam int EMIT_W      = 5;

  // The reported number of counters at the maximum saturates here.
  localparam logic [NUM_W-1:0] NUM_SAT = 5'd31;

  // Action codes; the unused codes behave as a read.
  localparam logic [ACTION_W-1:0] ACT_INC  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_DEC  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_CLR  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_READ = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_LIST = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // register the request and read the target counter
    logic modify;     // apply the action and write the counter back
    logic ptr_clr;    // restart the scan pointer
    logic scan_rd;    // read the next counter for the maximum scan
    logic list_rd;    // read the next counter for the listing
    logic emit_item;  // load the single result of a non-listing action
    logic emit_list;  // load the result for the counter just checked
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;   // every counter has been read
    logic is_list;    // the request is a listing
    logic match;      // the counter just read holds the maximum
    logic last_entry; // the next listed result is the final one
    logic out_free;   // the output register can take a result
  } status_t;

endpackage

`default_nettype wire

[hdl/cbmt_if.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on cbmt_pkg for the field widths.
`default_nettype none

interface cbmt_req_if;
  logic                              valid;
  logic                              ready;
  logic [cbmt_pkg::ACTION_W-1:0]     action;
  logic [cbmt_pkg::INDEX_W-1:0]      counter_index;

  modport source (output valid, action, counter_index, input ready);
  modport sink   (input valid, action, counter_index, output ready);
endinterface

interface cbmt_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [cbmt_pkg::INDEX_W-1:0]      result_index;
  logic signed [cbmt_pkg::VALUE_W-1:0] count_value;
  logic signed [cbmt_pkg::VALUE_W-1:0] max_value;
  logic [cbmt_pkg::NUM_W-1:0]        num_at_max;
  logic                              last;

  modport source (output valid, result_index, count_value, max_value, num_at_max, last,
                  input ready);
  modport sink   (input valid, result_index, count_value, max_value, num_at_max, last,
                  output ready);
endinterface

`default_nettype wire

[hdl/counter_bank_with_max_tracking.sv]
// Top level of the counter bank with maximum tracking.
// Instantiates cbmt_ctrl and cbmt_dp; uses cbmt_pkg and the cbmt_if interfaces.
//
// The block holds COUNTERS signed saturating counters of COUNT_BITS bits, all
// zero after reset, and takes one request at a time. Each request increments,
// decrements, clears or reads one counter, or lists the counters at the
// maximum. After the action the whole bank is scanned, one counter per cycle
// through the single port of the counter memory. A non-listing request has its
// result loaded once the scan ends, and the next request can be taken after
// that. A listing instead reads and checks the counters in turn, loading a
// result for each one at the maximum, up to the last one listed. Any output
// stall delays the loading of a result. A result waiting in the output
// register does not hold off the next request.
`default_nettype none

module counter_bank_with_max_tracking #(
  parameter int COUNTERS   = 16,
  parameter int COUNT_BITS = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  cbmt_req_if.sink   req,
  cbmt_rsp_if.source rsp
);

  cbmt_pkg::cmd_t    cmd;
  cbmt_pkg::status_t st;

  // Sequencing.
  cbmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  cbmt_dp #(
    .COUNTERS   (COUNTERS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .st  (st),
    .req (req),
    .rsp (rsp)
  );

endmodule

`default_nettype wire

[hdl/cbmt_ctrl.sv]
// Controller state machine for the counter bank.
// Sequences capture, update, maximum scan and result delivery; uses cbmt_pkg.
`default_nettype none

module cbmt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire cbmt_pkg::status_t st,
  output cbmt_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_RES,
    S_LRD,
    S_LCHK
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_MOD;
        end
      end
      S_MOD: begin
        cmd.modify  = 1'b1;
        cmd.ptr_clr = 1'b1;
        state_next  = S_SCAN;
      end
      S_SCAN: begin
        if (st.scan_end) begin
          cmd.ptr_clr = 1'b1;
          state_next  = st.is_list ? S_LRD : S_RES;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      S_RES: begin
        if (st.out_free) begin
          cmd.emit_item = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_LRD: begin
        cmd.list_rd = 1'b1;
        state_next  = S_LCHK;
      end
      S_LCHK: begin
        if (!st.match) begin
          state_next = S_LRD;
        end else if (st.out_free) begin
          cmd.emit_list = 1'b1;
          state_next    = st.last_entry ? S_IDLE : S_LRD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/cbmt_dp.sv]
// Datapath for the counter bank: counter memory, saturating update,
// running maximum scan and the output register. Uses cbmt_pkg and cbmt_if.
`default_nettype none

module cbmt_dp #(
  parameter int COUNTERS   = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire cbmt_pkg::cmd_t cmd,
  output cbmt_pkg::status_t   st,
  cbmt_req_if.sink            req,
  cbmt_rsp_if.source          rsp
);

  localparam int AW = (COUNTERS > 1) ? $clog2(COUNTERS) : 1;
  localparam int CW = $clog2(COUNTERS + 1);
  localparam int SW = ((CW > cbmt_pkg::EMIT_W) ? CW : cbmt_pkg::EMIT_W) + 1;

  localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic signed [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  // Counter memory; an entry never written reads as zero.
  logic signed [COUNT_BITS-1:0] mem [COUNTERS];
  logic [COUNTERS-1:0]          vbit;
  logic signed [COUNT_BITS-1:0] rd_data;
  logic                         rd_vb;

  // Request registers.
  logic [cbmt_pkg::ACTION_W-1:0] act;
  logic [cbmt_pkg::INDEX_W-1:0]  idx;
  logic                          idx_ok;
  logic [AW-1:0]                 addr;

  // Scan state.
  logic [CW-1:0]                 ptr;
  logic                          pend;
  logic                          first;
  logic signed [COUNT_BITS-1:0]  mx;
  logic [CW-1:0]                 num;
  logic [cbmt_pkg::EMIT_W-1:0]   emitted;
  logic signed [COUNT_BITS-1:0]  cur_val;

  // Output register.
  logic                                 o_valid;
  logic [cbmt_pkg::INDEX_W-1:0]         o_index;
  logic signed [cbmt_pkg::VALUE_W-1:0]  o_count;
  logic signed [cbmt_pkg::VALUE_W-1:0]  o_max;
  logic [cbmt_pkg::NUM_W-1:0]           o_num;
  logic                                 o_last;

  logic                         in_ok;
  logic [AW-1:0]                in_addr;
  logic [AW-1:0]                raddr;
  logic                         re;
  logic signed [COUNT_BITS-1:0] rd_val;
  logic signed [COUNT_BITS-1:0] new_val;
  logic [SW-1:0]                lim;
  logic [cbmt_pkg::NUM_W-1:0]   num_sat;

  // Address selection: the request index at capture, else the scan pointer.
  always_comb begin
    in_ok   = (32'(req.counter_index) < 32'(COUNTERS));
    in_addr = in_ok ? AW'(req.counter_index) : '0;
    raddr   = cmd.capture ? in_addr : ptr[AW-1:0];
    re      = cmd.capture | cmd.scan_rd | cmd.list_rd;
    rd_val  = rd_vb ? rd_data : '0;
  end

  // Saturating update of the target counter.
  always_comb begin
    case (act)
      cbmt_pkg::ACT_INC: new_val = (rd_val != CNT_MAX) ? rd_val + CNT_ONE : rd_val;
      cbmt_pkg::ACT_DEC: new_val = (rd_val != CNT_MIN) ? rd_val - CNT_ONE : rd_val;
      cbmt_pkg::ACT_CLR: new_val = '0;
      default:           new_val = rd_val;
    endcase
  end

  // Memory port: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.modify && idx_ok) begin
      mem[addr] <= new_val;
    end
    if (re) begin
      rd_data <= mem[raddr];
      rd_vb   <= vbit[raddr];
    end
  end

  // Written flags, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vbit <= '0;
    end else if (cmd.modify && idx_ok) begin
      vbit[addr] <= 1'b1;
    end
  end

  // Request capture and the value reported for the named counter.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act    <= req.action;
      idx    <= req.counter_index;
      idx_ok <= in_ok;
      addr   <= in_addr;
    end
    if (cmd.modify) begin
      cur_val <= idx_ok ? new_val : '0;
    end
  end

  // Scan pointer, read tracking and emitted count.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= '0;
      pend    <= 1'b0;
      emitted <= '0;
    end else begin
      pend <= cmd.scan_rd;
      if (cmd.ptr_clr) begin
        ptr     <= '0;
        emitted <= '0;
      end else begin
        if (cmd.scan_rd || cmd.list_rd) begin
          ptr <= ptr + CW'(1);
        end
        if (cmd.emit_list) begin
          emitted <= emitted + cbmt_pkg::EMIT_W'(1);
        end
      end
    end
  end

  // Running maximum and the number of counters that hold it.
  always_ff @(posedge clk) begin
    if (cmd.modify) begin
      first <= 1'b1;
    end else if (pend) begin
      if (first || (rd_val > mx)) begin
        mx    <= rd_val;
        num   <= CW'(1);
        first <= 1'b0;
      end else if (rd_val == mx) begin
        num <= num + CW'(1);
      end
    end
  end

  // Listing length and the saturated count for the result.
  always_comb begin
    lim     = (SW'(num) > SW'(cbmt_pkg::MAX_RESULTS)) ? SW'(cbmt_pkg::MAX_RESULTS) : SW'(num);
    num_sat = (SW'(num) > SW'(cbmt_pkg::NUM_SAT)) ? cbmt_pkg::NUM_SAT
                                                   : cbmt_pkg::NUM_W'(num);
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (cmd.emit_item || cmd.emit_list) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.emit_item) begin
      o_index <= idx;
      o_count <= cbmt_pkg::VALUE_W'(cur_val);
      o_max   <= cbmt_pkg::VALUE_W'(mx);
      o_num   <= num_sat;
      o_last  <= 1'b1;
    end else if (cmd.emit_list) begin
      o_index <= cbmt_pkg::INDEX_W'(ptr - CW'(1));
      o_count <= cbmt_pkg::VALUE_W'(mx);
      o_max   <= cbmt_pkg::VALUE_W'(mx);
      o_num   <= num_sat;
      o_last  <= st.last_entry;
    end
  end

  // Status towards the controller.
  always_comb begin
    st.scan_end   = (ptr == CW'(COUNTERS));
    st.is_list    = (act == cbmt_pkg::ACT_LIST);
    st.match      = (rd_val == mx);
    st.last_entry = ((SW'(emitted) + SW'(1)) == lim);
    st.out_free   = !o_valid || rsp.ready;
  end

  assign rsp.valid        = o_valid;
  assign rsp.result_index = o_index;
  assign rsp.count_value  = o_count;
  assign rsp.max_value    = o_max;
  assign rsp.num_at_max   = o_num;
  assign rsp.last         = o_last;

endmodule

`default_nettype wire

[hdl/cbmt_check.sv]
// Port-level checks for the counter bank, attached to the top level by bind.
// Depends on cbmt_pkg for field widths.
`default_nettype none

module cbmt_check (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                req_valid,
  input wire logic                                req_ready,
  input wire logic                                rsp_valid,
  input wire logic                                rsp_ready,
  input wire logic [cbmt_pkg::INDEX_W-1:0]        result_index,
  input wire logic signed [cbmt_pkg::VALUE_W-1:0] count_value,
  input wire logic signed [cbmt_pkg::VALUE_W-1:0] max_value,
  input wire logic [cbmt_pkg::NUM_W-1:0]          num_at_max,
  input wire logic                                last
);

  // A stalled result holds its index, count and last flag.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_index) && $stable(count_value)
                                && $stable(last))
    else $error("result changed while stalled");

  // One request at a time: no new transaction directly after one is taken.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous one is in progress");

  // Every result reports at least one counter at the maximum.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> num_at_max != '0)
    else $error("zero counters at the maximum");

  // Only listings give non-final results, and those carry the maximum.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !last |-> count_value == max_value)
    else $error("listed counter is not at the maximum");

endmodule

bind counter_bank_with_max_tracking cbmt_check u_check (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .result_index (rsp.result_index),
  .count_value  (rsp.count_value),
  .max_value    (rsp.max_value),
  .num_at_max   (rsp.num_at_max),
  .last         (rsp.last)
);

`default_nettype wire
